/* rtl/cfwh_pkg.sv */
package cfwh_pkg;

  // Store and field sizes
  localparam int MAX_BINS  = 1024;
  localparam int ADDR_W    = $clog2(MAX_BINS);
  localparam int NBINS_W   = $clog2(MAX_BINS + 1);
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 10;
  localparam int CMD_W     = 2;
  localparam int BCNT_W    = 11;
  localparam int REG_IDX_W = 2;
  localparam int DIV_CNT_W = $clog2(DATA_W);
  localparam int PROD_W    = IDX_W + 1 + DATA_W;
  localparam int EDGE_W    = PROD_W + 1;

  // Job queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_START = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COUNT = 2'd2;

  localparam logic [DATA_W-1:0] WIDTH_RESET = 32'h0001_0000;
  localparam logic [DATA_W-1:0] SAT_MAX     = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN     = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_ADD,
    OP_READ
  } op_t;

  // One classified item waiting for the back end
  typedef struct packed {
    op_t               op;
    logic [DATA_W:0]   diff;      // sample - start, 33 bit two's complement
    logic              zero_bin;  // quotient known to be at or below zero
    logic [IDX_W-1:0]  idx;
  } job_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] start_value;
    logic signed [DATA_W-1:0] bin_width;
    logic [NBINS_W-1:0]       nbins;
  } cfg_t;

  typedef struct packed {
    logic push;
    job_t job;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_rd_t;

endpackage

/* rtl/cfwh_ram.sv */
module cfwh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/cfwh_front.sv */
module cfwh_front import cfwh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [CMD_W-1:0]     cmd,
  input  logic signed [DATA_W-1:0] sample,
  input  logic                 sample_is_nan,
  input  logic [IDX_W-1:0]     bin_index,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  input  logic                 q_full,
  input  logic                 clearing,
  output logic                 busy,
  output cfg_t                 cfg,
  output q_wr_t                wr
);

  logic signed [DATA_W-1:0] start_value;
  logic signed [DATA_W-1:0] bin_width;
  logic [BCNT_W-1:0]        bin_count_in_use;
  logic [NBINS_W-1:0]       nbins;
  logic [DATA_W:0]          diff;
  logic                     accept;
  logic                     counting_on;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_value      <= '0;
      bin_width        <= WIDTH_RESET;
      bin_count_in_use <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START: start_value      <= cfg_data;
        REG_WIDTH: bin_width        <= cfg_data;
        REG_COUNT: bin_count_in_use <= cfg_data[BCNT_W-1:0];
        default:   ;
      endcase
    end
  end

  // Bins in use, limited to the store size
  assign nbins = (32'(bin_count_in_use) > 32'(MAX_BINS)) ? NBINS_W'(MAX_BINS)
                                                           : NBINS_W'(bin_count_in_use);

  assign cfg.start_value = start_value;
  assign cfg.bin_width   = bin_width;
  assign cfg.nbins       = nbins;

  assign busy        = q_full | clearing;
  assign accept      = start & ~busy;
  assign counting_on = (nbins != '0) && (bin_width != '0);
  assign diff        = {sample[DATA_W-1], sample} - {start_value[DATA_W-1], start_value};

  // Classify the item; skipped adds and the unused code never reach the queue
  always_comb begin
    wr.job.diff     = diff;
    wr.job.idx      = bin_index;
    wr.job.zero_bin = (diff == '0) || (diff[DATA_W] != bin_width[DATA_W-1]);
    wr.job.op       = OP_CLEAR;
    wr.push         = 1'b0;
    case (cmd)
      CMD_CLEAR: begin
        wr.job.op = OP_CLEAR;
        wr.push   = accept;
      end
      CMD_ADD: begin
        wr.job.op = OP_ADD;
        wr.push   = accept & ~sample_is_nan & counting_on;
      end
      CMD_READ: begin
        wr.job.op = OP_READ;
        wr.push   = accept;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/cfwh_queue.sv */
module cfwh_queue import cfwh_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  q_wr_t wr,
  input  logic  pop,
  output q_rd_t rd,
  output logic  full
);

  job_t               slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full     = (count == Q_CNT_W'(Q_DEPTH));
  assign rd.valid = (count != '0);
  assign rd.job   = slots[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (wr.push) begin
      slots[wr_ptr] <= wr.job;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr.push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH-1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH-1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      if (wr.push && !pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (!wr.push && pop) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(wr.push && full))
    else $error("item pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && !rd.valid))
    else $error("item popped from empty queue");

endmodule

/* rtl/cfwh_back.sv */
module cfwh_back import cfwh_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  q_rd_t                    rd,
  output logic                     pop,
  output logic                     clearing,
  output logic                     done,
  output logic [DATA_W-1:0]        bin_total,
  output logic signed [DATA_W-1:0] bin_edge,
  output logic                     index_in_use
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_CLAMP,
    S_INC_RD,
    S_INC_WR,
    S_RD_EDGE
  } state_t;

  state_t                   state;
  logic [ADDR_W-1:0]        ptr;
  logic [DATA_W-1:0]        dvd;     // dividend, shifts into quotient
  logic [DATA_W-1:0]        rem;
  logic [DATA_W-1:0]        den;
  logic [DIV_CNT_W-1:0]     step;
  logic [ADDR_W-1:0]        bin;
  logic signed [PROD_W-1:0] prod;
  logic [IDX_W-1:0]         idx_r;

  logic [DATA_W:0]          rem_sh;
  logic [DATA_W:0]          rem_sub;
  logic                     fits;
  logic [DATA_W:0]          mag;
  logic [DATA_W-1:0]        den_mag;
  logic                     quot_big;
  logic [NBINS_W-1:0]       nb_last;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [EDGE_W-1:0] edge_sum;
  logic                     edge_ovf;
  logic [DATA_W-1:0]        edge_sat;
  logic [DATA_W-1:0]        inc;
  logic                     in_store;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [DATA_W-1:0]        ram_wdata;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [DATA_W-1:0]        ram_rdata;

  cfwh_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_BINS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Restoring divide step, one quotient bit a cycle
  assign rem_sh  = {rem, dvd[DATA_W-1]};
  assign rem_sub = rem_sh - {1'b0, den};
  assign fits    = (rem_sh >= {1'b0, den});

  // Operand magnitudes; signs already agree when the divider runs
  assign mag     = rd.job.diff[DATA_W] ? -rd.job.diff : rd.job.diff;
  assign den_mag = cfg.bin_width[DATA_W-1] ? -cfg.bin_width : cfg.bin_width;

  // Clamp to the last bin in use
  assign quot_big = ((DATA_W+1)'(dvd) >= (DATA_W+1)'(cfg.nbins));
  assign nb_last  = cfg.nbins - NBINS_W'(1);

  // Bin edge: product registered, then add and saturate
  assign prod_next = $signed({1'b0, rd.job.idx}) * cfg.bin_width;
  assign edge_sum  = EDGE_W'(prod) + EDGE_W'(cfg.start_value);
  assign edge_ovf  = ~((&edge_sum[EDGE_W-1:DATA_W-1]) | ~(|edge_sum[EDGE_W-1:DATA_W-1]));
  assign edge_sat  = edge_ovf ? (edge_sum[EDGE_W-1] ? SAT_MIN : SAT_MAX)
                              : edge_sum[DATA_W-1:0];

  // Saturating counter increment
  assign inc      = (&ram_rdata) ? ram_rdata : ram_rdata + DATA_W'(1);
  assign in_store = (32'(idx_r) < 32'(MAX_BINS));

  assign pop = (state == S_IDLE) && rd.valid;

  // Store port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = bin;
    ram_wdata = inc;
    ram_raddr = bin;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr;
        ram_wdata = '0;
      end
      S_INC_WR: ram_we = 1'b1;
      S_IDLE:   ram_raddr = ADDR_W'(rd.job.idx);
      default:  ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      ptr      <= '0;
      clearing <= 1'b1;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          ptr <= ptr + ADDR_W'(1);
          if (ptr == ADDR_W'(MAX_BINS-1)) begin
            state    <= S_IDLE;
            clearing <= 1'b0;
          end
        end
        S_IDLE: begin
          if (rd.valid) begin
            case (rd.job.op)
              OP_CLEAR: begin
                ptr   <= '0;
                state <= S_CLEAR;
              end
              OP_ADD: begin
                if (rd.job.zero_bin) begin
                  bin   <= '0;
                  state <= S_INC_RD;
                end else begin
                  dvd   <= mag[DATA_W-1:0];
                  rem   <= '0;
                  den   <= den_mag;
                  step  <= '0;
                  state <= S_DIV;
                end
              end
              OP_READ: begin
                prod  <= prod_next;
                idx_r <= rd.job.idx;
                state <= S_RD_EDGE;
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          rem  <= fits ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
          dvd  <= {dvd[DATA_W-2:0], fits};
          step <= step + DIV_CNT_W'(1);
          if (step == DIV_CNT_W'(DATA_W-1)) begin
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          bin   <= quot_big ? ADDR_W'(nb_last) : ADDR_W'(dvd);
          state <= S_INC_RD;
        end
        S_INC_RD: state <= S_INC_WR;
        S_INC_WR: state <= S_IDLE;
        S_RD_EDGE: begin
          bin_total    <= in_store ? ram_rdata : '0;
          bin_edge     <= edge_sat;
          index_in_use <= (32'(idx_r) < 32'(cfg.nbins));
          done         <= 1'b1;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_from_read: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_RD_EDGE)
    else $error("result strobe without a read");
  a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !pop)
    else $error("item taken during initial clear");
  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state != S_IDLE)
    else $error("popped item not executed");

endmodule

/* rtl/clamped_fixed_width_histogram_top.sv */
// Histogram with equal-width bins over signed Q16.16 samples. An item is taken when start
// is high and busy is low; results appear for one cycle on done and cannot be held off.
// After reset the counter store is swept to zero with busy high. Items pass through a
// two-entry queue to a sequencer, and busy rises when that queue is full. For a read the
// idle state pops the item and registers the edge product; the edge state then adds,
// saturates and raises done. An add runs dispatch, the restoring divider (one quotient
// bit a cycle, 32 steps), clamp and counter read-modify-write; an add whose quotient
// is at or below zero skips divider and clamp. A clear command sweeps the store to zero.
// Skipped adds (not a number, no bins or zero width) and the unused code are dropped.
module clamped_fixed_width_histogram_top import cfwh_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         cmd,
  input  logic signed [DATA_W-1:0] sample,
  input  logic                     sample_is_nan,
  input  logic [IDX_W-1:0]         bin_index,
  input  logic                     cfg_we,
  input  logic [REG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  output logic                     done,
  output logic [DATA_W-1:0]        bin_total,
  output logic signed [DATA_W-1:0] bin_edge,
  output logic                     index_in_use
);

  cfg_t  cfg;
  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;
  logic  clearing;

  cfwh_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .cmd           (cmd),
    .sample        (sample),
    .sample_is_nan (sample_is_nan),
    .bin_index     (bin_index),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_full        (q_full),
    .clearing      (clearing),
    .busy          (busy),
    .cfg           (cfg),
    .wr            (q_wr)
  );

  cfwh_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (q_wr),
    .pop  (q_pop),
    .rd   (q_rd),
    .full (q_full)
  );

  cfwh_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .rd           (q_rd),
    .pop          (q_pop),
    .clearing     (clearing),
    .done         (done),
    .bin_total    (bin_total),
    .bin_edge     (bin_edge),
    .index_in_use (index_in_use)
  );

endmodule
